// ===== hdl/nbe_pkg.sv =====
// noekeon block encrypt package: block type, round constants and round functions
`default_nettype none
package nbe_pkg;

    typedef logic [3:0][31:0] block_t;

    typedef struct packed {
        logic   valid;
        block_t data;
    } stage_t;

    typedef enum logic {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_index_t;

    localparam int MAX_ROUNDS = 16;

    localparam logic [7:0] ROUND_CONST [0:MAX_ROUNDS] = '{
        8'h80, 8'h1b, 8'h36, 8'h6c, 8'hd8, 8'hab, 8'h4d, 8'h9a, 8'h2f,
        8'h5e, 8'hbc, 8'h63, 8'hc6, 8'h97, 8'h35, 8'h6a, 8'hd4
    };

    function automatic logic [31:0] mix8(input logic [31:0] x);
        return x ^ {x[7:0], x[31:8]} ^ {x[23:0], x[31:24]};
    endfunction

    function automatic block_t theta(input block_t k, input block_t w);
        block_t     r;
        logic [31:0] t;
        r = w;
        t = mix8(r[0] ^ r[2]);
        r[1] = r[1] ^ t;
        r[3] = r[3] ^ t;
        r = r ^ k;
        t = mix8(r[1] ^ r[3]);
        r[0] = r[0] ^ t;
        r[2] = r[2] ^ t;
        return r;
    endfunction

    function automatic block_t gamma(input block_t w);
        block_t      r;
        logic [31:0] t;
        r = w;
        r[1] = r[1] ^ (~r[3] & ~r[2]);
        r[0] = r[0] ^ (r[2] & r[1]);
        t    = r[3];
        r[3] = r[0];
        r[0] = t;
        r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
        r[1] = r[1] ^ (~r[3] & ~r[2]);
        r[0] = r[0] ^ (r[2] & r[1]);
        return r;
    endfunction

    function automatic block_t round_step(input block_t k, input block_t w,
                                          input logic [7:0] rc);
        block_t r;
        r = w;
        r[0] = r[0] ^ {24'h0, rc};
        r = theta(k, r);
        r[1] = {r[1][30:0], r[1][31]};
        r[2] = {r[2][26:0], r[2][31:27]};
        r[3] = {r[3][29:0], r[3][31:30]};
        r = gamma(r);
        r[1] = {r[1][0], r[1][31:1]};
        r[2] = {r[2][4:0], r[2][31:5]};
        r[3] = {r[3][1:0], r[3][31:2]};
        return r;
    endfunction

    function automatic block_t final_step(input block_t k, input block_t w,
                                          input logic [7:0] rc);
        block_t r;
        r = w;
        r[0] = r[0] ^ {24'h0, rc};
        return theta(k, r);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/nbe_round_cell.sv =====
// noekeon block encrypt: one round cell of the pipeline chain
`default_nettype none
module nbe_round_cell #(
    parameter int RND = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire nbe_pkg::block_t key,
    input  wire nbe_pkg::stage_t prev,
    output nbe_pkg::stage_t      stage
);
    import nbe_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    block_t data_reg;
    block_t data_next;

    always_comb
    begin
        valid_next = advance ? prev.valid : valid_reg;
        data_next  = advance ? round_step(key, prev.data, ROUND_CONST[RND]) : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule
`default_nettype wire

// ===== hdl/nbe_out_cell.sv =====
// noekeon block encrypt: final whitening cell and output register
`default_nettype none
module nbe_out_cell #(
    parameter int RND = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire nbe_pkg::block_t key,
    input  wire nbe_pkg::stage_t prev,
    output nbe_pkg::stage_t      stage
);
    import nbe_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    block_t data_reg;
    block_t data_next;

    always_comb
    begin
        valid_next = advance ? prev.valid : valid_reg;
        data_next  = advance ? final_step(key, prev.data, ROUND_CONST[RND]) : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule
`default_nettype wire

// ===== hdl/noekeon_block_encrypt_core.sv =====
// noekeon block encrypt: top level with key registers and the chain of round cells
`default_nettype none
// NOEKEON 128-bit encryption in direct-key mode. The key is loaded through the
// write port (index 0 = key words 1:0, index 1 = key words 3:2) and must only be
// changed while no item is in flight. Each round is one registered cell in a
// chain, followed by an output cell that registers the final whitening
// (ROUND_COUNT held to 1..16). A new item is accepted every cycle unless the
// output is held: when the output is not taken the whole chain
// holds.
module noekeon_block_encrypt_core #(
    parameter int ROUND_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] plain_low,
    input  wire logic [63:0] plain_high,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      cipher_low,
    output logic [63:0]      cipher_high
);
    import nbe_pkg::*;

    // round count held within the constant table
    localparam int ROUNDS_USED = (ROUND_COUNT > MAX_ROUNDS) ? MAX_ROUNDS :
                                 (ROUND_COUNT < 1) ? 1 : ROUND_COUNT;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    block_t      key;
    logic        advance;
    stage_t      chain [0:ROUNDS_USED];
    stage_t      out_stage;
    logic [ROUNDS_USED:1] chain_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_KEY_LOW:  key_low_reg  <= cfg_wr_data;
                REG_KEY_HIGH: key_high_reg <= cfg_wr_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign key      = block_t'({key_high_reg, key_low_reg});
    assign advance  = !out_stage.valid || out_ready;
    assign in_ready = advance;

    assign chain[0].valid = in_valid;
    assign chain[0].data  = block_t'({plain_high, plain_low});

    for (genvar i = 0; i < ROUNDS_USED; i++)
    begin : g_round
        nbe_round_cell #(
            .RND (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .key     (key),
            .prev    (chain[i]),
            .stage   (chain[i+1])
        );
    end

    for (genvar j = 1; j <= ROUNDS_USED; j++)
    begin : g_valid
        assign chain_valid[j] = chain[j].valid;
    end

    nbe_out_cell #(
        .RND (ROUNDS_USED)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .key     (key),
        .prev    (chain[ROUNDS_USED]),
        .stage   (out_stage)
    );

    assign out_valid   = out_stage.valid;
    assign cipher_low  = {out_stage.data[1], out_stage.data[0]};
    assign cipher_high = {out_stage.data[3], out_stage.data[2]};

`ifndef SYNTHESIS
    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(chain_valid))
        else $error("round chain moved during a stall");

    a_last_round_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && chain_valid[ROUNDS_USED]) |=> out_valid)
        else $error("item from last round did not reach the output");

    a_no_phantom_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !chain_valid[ROUNDS_USED]) |=> !out_valid)
        else $error("output valid without an item from the last round");
`endif

endmodule
`default_nettype wire

// ===== tb/noekeon_block_encrypt_core_tb.sv =====
// testbench for the noekeon block encrypt core: random bursts, stalls and key changes
`default_nettype none
module noekeon_block_encrypt_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nbe_pkg::*;

    localparam int ROUNDS       = 16;
    localparam int SETTLE_TICKS = 2 * (ROUNDS + 1) + 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BLOCKS = 262;

    localparam logic [7:0] RC_TABLE [0:16] = '{
        8'h80, 8'h1b, 8'h36, 8'h6c, 8'hd8, 8'hab, 8'h4d, 8'h9a, 8'h2f,
        8'h5e, 8'hbc, 8'h63, 8'hc6, 8'h97, 8'h35, 8'h6a, 8'hd4
    };

    class cipher_scoreboard;
        block_t key;
        block_t expected_q[$];
        int     errors;

        function new();
            key    = '0;
            errors = 0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function logic [31:0] spread(logic [31:0] x);
            return x ^ rol(x, 8) ^ rol(x, 24);
        endfunction

        function block_t keyed_theta(block_t w);
            block_t      v;
            logic [31:0] t;
            v = w;
            t = spread(v[0] ^ v[2]);
            v[1] = v[1] ^ t;
            v[3] = v[3] ^ t;
            for (int i = 0; i < 4; i++)
            begin
                v[i] = v[i] ^ key[i];
            end
            t = spread(v[1] ^ v[3]);
            v[0] = v[0] ^ t;
            v[2] = v[2] ^ t;
            return v;
        endfunction

        function block_t sbox_layer(block_t w);
            block_t      v;
            logic [31:0] t;
            v = w;
            v[1] = v[1] ^ (~v[3] & ~v[2]);
            v[0] = v[0] ^ (v[2] & v[1]);
            t    = v[3];
            v[3] = v[0];
            v[0] = t;
            v[2] = v[2] ^ v[0] ^ v[1] ^ v[3];
            v[1] = v[1] ^ (~v[3] & ~v[2]);
            v[0] = v[0] ^ (v[2] & v[1]);
            return v;
        endfunction

        function block_t encrypt(block_t plain);
            block_t w;
            w = plain;
            for (int r = 0; r < ROUNDS; r++)
            begin
                w[0] = w[0] ^ {24'h0, RC_TABLE[r]};
                w    = keyed_theta(w);
                w[1] = rol(w[1], 1);
                w[2] = rol(w[2], 5);
                w[3] = rol(w[3], 2);
                w    = sbox_layer(w);
                w[1] = rol(w[1], 31);
                w[2] = rol(w[2], 27);
                w[3] = rol(w[3], 30);
            end
            w[0] = w[0] ^ {24'h0, RC_TABLE[ROUNDS]};
            return keyed_theta(w);
        endfunction

        function void set_key_half(reg_index_t idx, logic [63:0] value);
            if (idx == REG_KEY_LOW)
            begin
                key[1:0] = value;
            end
            else
            begin
                key[3:2] = value;
            end
        endfunction

        function void note_block(logic [63:0] lo, logic [63:0] hi);
            expected_q.push_back(encrypt({hi, lo}));
        endfunction

        function void check_block(logic [63:0] lo, logic [63:0] hi);
            block_t exp_blk;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected cipher block %h_%h", $time, hi, lo);
                errors++;
                return;
            end
            exp_blk = expected_q.pop_front();
            if (exp_blk[1:0] !== lo)
            begin
                $display("%0t: cipher_low expected %h actual %h",
                         $time, exp_blk[1:0], lo);
                errors++;
            end
            if (exp_blk[3:2] !== hi)
            begin
                $display("%0t: cipher_high expected %h actual %h",
                         $time, exp_blk[3:2], hi);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    reg_index_t  cfg_index;
    logic [63:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] plain_low;
    logic [63:0] plain_high;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;

    cipher_scoreboard sb;
    int               cycles;
    int               rx_mode;
    int               rx_count;

    noekeon_block_encrypt_core #(
        .ROUND_COUNT(ROUNDS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .plain_low  (plain_low),
        .plain_high (plain_high),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cipher_low (cipher_low),
        .cipher_high(cipher_high)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // item monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_block(plain_low, plain_high);
            end
            if (out_valid && out_ready)
            begin
                sb.check_block(cipher_low, cipher_high);
            end
        end
    end

    // receiver stall pattern, mode picked anew at random when its counter runs out
    always @(posedge clk)
    begin
        if (rx_count == 0)
        begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= $urandom_range(20, 120);
        end
        else
        begin
            rx_count <= rx_count - 1;
        end
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= (rx_count % 5) != 0;
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic logic [63:0] pick_half();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            4: return {32'h0, 32'h80};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
        in_valid   <= 1'b1;
        plain_low  <= lo;
        plain_high <= hi;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_keys(input logic [63:0] lo, input logic [63:0] hi);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_KEY_LOW;
        cfg_wr_data <= lo;
        @(posedge clk);
        cfg_index   <= REG_KEY_HIGH;
        cfg_wr_data <= hi;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_key_half(REG_KEY_LOW, lo);
        sb.set_key_half(REG_KEY_HIGH, hi);
    endtask

    task automatic run_bursts(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 48);
            if (burst > count - sent)
            begin
                burst = count - sent;
            end
            repeat (burst) send_block(pick_half(), pick_half());
            sent += burst;
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(1, 12);
                default: gap = $urandom_range(0, 30);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic run_directed();
        send_block('0, '0);
        send_block('1, '1);
        send_block('1, '0);
        send_block('0, '1);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        // word 0 cancels the first round constant
        send_block({32'h0, 32'h80}, '0);
        send_block(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_block(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001);
        send_block(64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000);
        send_block(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        in_valid <= 1'b0;
        @(posedge clk);
        send_block(64'hdead_beef_0bad_f00d, 64'hcafe_babe_1234_5678);
    endtask

    initial
    begin
        sb          = new();
        cycles      = 0;
        rx_mode     = 0;
        rx_count    = 0;
        rst_n       = 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_KEY_LOW;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        plain_low   <= '0;
        plain_high  <= '0;
        out_ready   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key first, then explicit keys
        run_directed();
        settle();
        write_keys('0, '0);
        run_directed();
        run_bursts(PHASE_BLOCKS);
        settle();
        write_keys('1, '1);
        run_directed();
        run_bursts(PHASE_BLOCKS);
        settle();
        write_keys({$urandom, $urandom}, {$urandom, $urandom});
        run_bursts(PHASE_BLOCKS);
        settle();
        write_keys(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
        run_bursts(PHASE_BLOCKS);
        settle();
        write_keys(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        run_bursts(PHASE_BLOCKS);
        settle();
        write_keys({$urandom, $urandom}, {$urandom, $urandom});
        run_bursts(PHASE_BLOCKS);
        settle();
        write_keys(~{$urandom, $urandom}, {$urandom, $urandom});
        run_bursts(PHASE_BLOCKS - 40);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
